FILE: sv/hpid_pkg.sv
// Package for the heading PID: field widths, constants and stage types.
package hpid_pkg;

   localparam int HEADING_WIDTH   = 16;
   localparam int DUTY_WIDTH      = 13;
   localparam int OFFSET_WIDTH    = 24;
   localparam int GAIN_WIDTH      = 20;
   localparam int LIMIT_WIDTH     = 23;
   localparam int ERROR_WIDTH     = 15;
   localparam int SUM_WIDTH       = 24;
   localparam int DIFF_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 23;

   localparam int HALF_TURN  = 11520;
   localparam int FULL_TURN  = 23040;
   localparam int DUTY_MAX   = 6400;
   localparam int OFFSET_MAX = 8388607;
   localparam int OFFSET_MIN = -8388608;

   localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RESET      = 20'd65536;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_I_DT_RESET   = 20'd131;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_D_DT_RESET   = 20'd163840;
   localparam logic [LIMIT_WIDTH-1:0] SUM_LIMIT_RESET   = 23'd320000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I_DT      = 3'd1,
      CSR_GAIN_D_OVER_DT = 3'd2,
      CSR_SUM_LIMIT      = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  gain_p;
      logic [GAIN_WIDTH-1:0]  gain_i_dt;
      logic [GAIN_WIDTH-1:0]  gain_d_over_dt;
      logic [LIMIT_WIDTH-1:0] sum_limit;
   } csr_type;

   // Stage between error tracking and the gain/mix stage.
   typedef struct packed {
      logic signed [ERROR_WIDTH-1:0] err;
      logic signed [SUM_WIDTH-1:0]   sum;
      logic signed [DIFF_WIDTH-1:0]  diff;
      logic [DUTY_WIDTH-1:0]         base;
   } err_stage_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0]          left_duty;
      logic [DUTY_WIDTH-1:0]          right_duty;
      logic signed [OFFSET_WIDTH-1:0] steer_offset;
   } result_type;

endpackage

FILE: sv/hpid_if.sv
// Handshake interfaces for the request, response and CSR channels.
interface hpid_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [hpid_pkg::HEADING_WIDTH-1:0] target_heading;
   logic signed [hpid_pkg::HEADING_WIDTH-1:0] measured_heading;
   logic [hpid_pkg::DUTY_WIDTH-1:0]           base_duty;

   modport source (output valid, target_heading, measured_heading, base_duty, input ready);
   modport sink   (input valid, target_heading, measured_heading, base_duty, output ready);
endinterface

interface hpid_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [hpid_pkg::DUTY_WIDTH-1:0]          left_duty;
   logic [hpid_pkg::DUTY_WIDTH-1:0]          right_duty;
   logic signed [hpid_pkg::OFFSET_WIDTH-1:0] steer_offset;

   modport source (output valid, left_duty, right_duty, steer_offset, input ready);
   modport sink   (input valid, left_duty, right_duty, steer_offset, output ready);
endinterface

interface hpid_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [hpid_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [hpid_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hpid_error.sv
// Heading error wrap, anti-windup error sum and previous-error state.
module hpid_error (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      update,
   input  logic signed [hpid_pkg::HEADING_WIDTH-1:0] target_heading,
   input  logic signed [hpid_pkg::HEADING_WIDTH-1:0] measured_heading,
   input  logic [hpid_pkg::DUTY_WIDTH-1:0]           base_duty,
   input  logic [hpid_pkg::LIMIT_WIDTH-1:0]          sum_limit,
   output hpid_pkg::err_stage_type                   stage
);

   localparam int WRAP_WIDTH = hpid_pkg::HEADING_WIDTH + 2;
   localparam int RAW_WIDTH  = hpid_pkg::SUM_WIDTH + 1;

   logic signed [hpid_pkg::ERROR_WIDTH-1:0] last_error_ff, last_error_in;
   logic signed [hpid_pkg::SUM_WIDTH-1:0]   error_sum_ff, error_sum_in;
   logic signed [WRAP_WIDTH-1:0]            wrap [4];
   logic signed [RAW_WIDTH-1:0]             sum_raw;
   logic signed [RAW_WIDTH-1:0]             lim_pos;
   logic signed [RAW_WIDTH-1:0]             lim_neg;

   // Difference of two 16-bit headings needs at most three full-turn steps.
   always_comb begin
      wrap[0] = WRAP_WIDTH'(target_heading) - WRAP_WIDTH'(measured_heading);
      for (int i = 0; i < 3; i++) begin
         if (wrap[i] > hpid_pkg::HALF_TURN) begin
            wrap[i+1] = wrap[i] - WRAP_WIDTH'(hpid_pkg::FULL_TURN);
         end else if (wrap[i] < -hpid_pkg::HALF_TURN) begin
            wrap[i+1] = wrap[i] + WRAP_WIDTH'(hpid_pkg::FULL_TURN);
         end else begin
            wrap[i+1] = wrap[i];
         end
      end
   end

   always_comb begin
      last_error_in = wrap[3][hpid_pkg::ERROR_WIDTH-1:0];
      sum_raw = RAW_WIDTH'(error_sum_ff) + RAW_WIDTH'(last_error_in);
      lim_pos = $signed({2'b00, sum_limit});
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos) begin
         error_sum_in = lim_pos[hpid_pkg::SUM_WIDTH-1:0];
      end else if (sum_raw < lim_neg) begin
         error_sum_in = lim_neg[hpid_pkg::SUM_WIDTH-1:0];
      end else begin
         error_sum_in = sum_raw[hpid_pkg::SUM_WIDTH-1:0];
      end
      stage.err  = last_error_in;
      stage.sum  = error_sum_in;
      stage.diff = hpid_pkg::DIFF_WIDTH'(last_error_in) - hpid_pkg::DIFF_WIDTH'(last_error_ff);
      stage.base = base_duty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (update) begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

endmodule

FILE: sv/hpid_mix.sv
// Gain products, offset saturation and left/right duty mixing.
module hpid_mix (
   input  hpid_pkg::err_stage_type stage,
   input  hpid_pkg::csr_type       csr,
   output hpid_pkg::result_type    result
);

   localparam int GS_WIDTH   = hpid_pkg::GAIN_WIDTH + 1;
   localparam int PP_WIDTH   = GS_WIDTH + hpid_pkg::ERROR_WIDTH;
   localparam int PI_WIDTH   = GS_WIDTH + hpid_pkg::SUM_WIDTH;
   localparam int PD_WIDTH   = GS_WIDTH + hpid_pkg::DIFF_WIDTH;
   localparam int SUM_W      = PI_WIDTH - 16 + 2;
   localparam int DUTY_RAW_W = hpid_pkg::OFFSET_WIDTH + 2;

   logic signed [GS_WIDTH-1:0]                 gp, gi, gd;
   logic signed [PP_WIDTH-1:0]                 prod_p;
   logic signed [PI_WIDTH-1:0]                 prod_i;
   logic signed [PD_WIDTH-1:0]                 prod_d;
   logic signed [SUM_W-1:0]                    offset_raw;
   logic signed [hpid_pkg::OFFSET_WIDTH-1:0]   offset;
   logic signed [DUTY_RAW_W-1:0]               base_ext, left_raw, right_raw;

   always_comb begin
      gp = $signed({1'b0, csr.gain_p});
      gi = $signed({1'b0, csr.gain_i_dt});
      gd = $signed({1'b0, csr.gain_d_over_dt});
      prod_p = PP_WIDTH'(gp) * PP_WIDTH'(stage.err);
      prod_i = PI_WIDTH'(gi) * PI_WIDTH'(stage.sum);
      prod_d = PD_WIDTH'(gd) * PD_WIDTH'(stage.diff);
      // Dropping the low 16 bits of a signed product is a floor shift.
      offset_raw = SUM_W'($signed(prod_p[PP_WIDTH-1:16]))
                 + SUM_W'($signed(prod_i[PI_WIDTH-1:16]))
                 + SUM_W'($signed(prod_d[PD_WIDTH-1:16]));
      if (offset_raw > hpid_pkg::OFFSET_MAX) begin
         offset = hpid_pkg::OFFSET_WIDTH'(hpid_pkg::OFFSET_MAX);
      end else if (offset_raw < hpid_pkg::OFFSET_MIN) begin
         offset = hpid_pkg::OFFSET_WIDTH'(hpid_pkg::OFFSET_MIN);
      end else begin
         offset = offset_raw[hpid_pkg::OFFSET_WIDTH-1:0];
      end

      base_ext  = $signed({{(DUTY_RAW_W-hpid_pkg::DUTY_WIDTH){1'b0}}, stage.base});
      left_raw  = base_ext + DUTY_RAW_W'(offset);
      right_raw = base_ext - DUTY_RAW_W'(offset);

      if (left_raw < 0) begin
         result.left_duty = '0;
      end else if (left_raw > hpid_pkg::DUTY_MAX) begin
         result.left_duty = hpid_pkg::DUTY_WIDTH'(hpid_pkg::DUTY_MAX);
      end else begin
         result.left_duty = left_raw[hpid_pkg::DUTY_WIDTH-1:0];
      end

      if (right_raw < 0) begin
         result.right_duty = '0;
      end else if (right_raw > hpid_pkg::DUTY_MAX) begin
         result.right_duty = hpid_pkg::DUTY_WIDTH'(hpid_pkg::DUTY_MAX);
      end else begin
         result.right_duty = right_raw[hpid_pkg::DUTY_WIDTH-1:0];
      end

      result.steer_offset = offset;
   end

endmodule

FILE: sv/heading_pid_differential_drive_top.sv
// Heading PID top level: CSR registers, pipeline registers and handshakes.
//
// Each request transaction carries a target heading, a measured heading
// (1/64 degree) and a base duty (1/64 percent). Each one yields exactly one
// response transaction with left duty, right duty and the saturated turn
// offset, in request order.
// Pipeline: input register, error/sum register, result register. A response
// is valid once its request has reached the result register; one request
// can be accepted every cycle while the response sink does not stall. The
// error sum and previous error are updated as an item leaves the input
// register, so back-to-back items see each other's state.
// When the response sink stalls, the whole pipeline holds and req_bus.ready
// drops; a waiting result stays put until taken.
// CSR writes (index 0 gain_p, 1 gain_i_dt, 2 gain_d_over_dt, 3 sum_limit)
// are always ready; the user must issue them only while the pipeline is
// empty, as the block does not enforce it; other indexes are ignored.
// Reset (synchronous, active high) empties the pipeline, clears the error sum
// and previous error, and loads the default gains and sum limit.
module heading_pid_differential_drive_top (
   input  logic        clock,
   input  logic        reset,
   hpid_req_if.sink    req_bus,
   hpid_rsp_if.source  rsp_bus,
   hpid_csr_if.sink    csr_bus
);

   hpid_pkg::csr_type       csr_ff;
   logic                    s0_valid_ff;
   logic signed [hpid_pkg::HEADING_WIDTH-1:0] s0_target_ff, s0_measured_ff;
   logic [hpid_pkg::DUTY_WIDTH-1:0]           s0_base_ff;
   logic                    s1_valid_ff;
   hpid_pkg::err_stage_type s1_stage_ff, s1_stage_in;
   logic                    rsp_valid_ff;
   hpid_pkg::result_type    rsp_result_ff, rsp_result_in;
   logic                    advance;
   logic                    req_fire;

   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire = req_bus.valid && advance;

   assign req_bus.ready        = advance;
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.left_duty    = rsp_result_ff.left_duty;
   assign rsp_bus.right_duty   = rsp_result_ff.right_duty;
   assign rsp_bus.steer_offset = rsp_result_ff.steer_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_p         <= hpid_pkg::GAIN_P_RESET;
         csr_ff.gain_i_dt      <= hpid_pkg::GAIN_I_DT_RESET;
         csr_ff.gain_d_over_dt <= hpid_pkg::GAIN_D_DT_RESET;
         csr_ff.sum_limit      <= hpid_pkg::SUM_LIMIT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            hpid_pkg::CSR_GAIN_P:
               csr_ff.gain_p <= csr_bus.data[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::CSR_GAIN_I_DT:
               csr_ff.gain_i_dt <= csr_bus.data[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::CSR_GAIN_D_OVER_DT:
               csr_ff.gain_d_over_dt <= csr_bus.data[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::CSR_SUM_LIMIT:
               csr_ff.sum_limit <= csr_bus.data[hpid_pkg::LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   hpid_error u_error (
      .clock            (clock),
      .reset            (reset),
      .update           (advance && s0_valid_ff),
      .target_heading   (s0_target_ff),
      .measured_heading (s0_measured_ff),
      .base_duty        (s0_base_ff),
      .sum_limit        (csr_ff.sum_limit),
      .stage            (s1_stage_in)
   );

   hpid_mix u_mix (
      .stage  (s1_stage_ff),
      .csr    (csr_ff),
      .result (rsp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_bus.valid;
         s1_valid_ff  <= s0_valid_ff;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_target_ff   <= req_bus.target_heading;
         s0_measured_ff <= req_bus.measured_heading;
         s0_base_ff     <= req_bus.base_duty;
      end
      if (advance) begin
         s1_stage_ff   <= s1_stage_in;
         rsp_result_ff <= rsp_result_in;
      end
   end

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s0_valid_ff)
      else $error("accepted request did not reach input register");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff |=> rsp_valid_ff)
      else $error("error stage item lost before result register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_stage_ff) && $stable(s1_valid_ff) && $stable(s0_valid_ff))
      else $error("pipeline moved during response stall");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.left_duty <= hpid_pkg::DUTY_MAX &&
                       rsp_result_ff.right_duty <= hpid_pkg::DUTY_MAX)
      else $error("duty out of range");

endmodule
